// ===== rtl/core/epm_pkg.sv =====
// ----------------------------------------------------------------------------
// epm_pkg: shared constants and types of the edge phase meter
// Widths, phase constants, register indexes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package epm_pkg;

  // Sample counters and the latched period (one bit wider than a counter).
  localparam int COUNT_BITS  = 24;
  localparam int PERIOD_BITS = COUNT_BITS + 1;

  // Samples and phase words.
  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_BITS  = 16;

  // The numerator of the phase division is count * full turn.
  localparam int TURN_BITS    = 17;
  localparam int NUM_BITS     = COUNT_BITS + 16;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam logic signed [SAMPLE_BITS-1:0] HIGH_THRESHOLD = 16'sd2048;
  localparam logic [TURN_BITS-1:0]          FULL_TURN      = 17'd46080;
  localparam logic [PHASE_BITS-1:0]         HALF_TURN      = 16'd23040;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_MODE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_MODE = 4'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // an input beat is taken: update edges and counters
    logic emit_sync;  // the accepted beat repeats the last phase
    logic mul;        // form the division numerator
    logic step;       // one restoring division step
    logic finish;     // wrap the phase and load the result register
  } epm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic x_edge;     // the offered input beat carries a signal edge
    logic sync_mode;  // repeat the last phase on beats without a signal edge
    logic div_last;   // the current division step is the final one
  } epm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/edge_phase_meter.sv =====
// ----------------------------------------------------------------------------
// edge_phase_meter: edge-counting phase meter
// Measures the phase of a sampled signal against a sampled reference by
// counting samples between selected edges, in 1/128 degree units.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Beat contents
//  in_      input      in_valid/in_stall   in_x_sample, in_ref_sample (Q3.12)
//  out_     output     out_valid/out_stall out_phase (1/128 degree, signed)
//  cfg_     input      cfg_wr_en           cfg_index, cfg_data (write only)
//
//  A beat without a signal edge is taken with no divide; in sync mode it
//  places the last phase in the result register in the same cycle.
//  A beat with a signal edge runs through its accept, the multiply by a
//  full turn, the bit-serial restoring divide of the 40-bit numerator by
//  the latched period, and the wrap of the phase into the result register
//  before the next beat is accepted.
//  Reset is synchronous and active low; it restores rising-edge and sync
//  mode and clears all counters, the period and the last phase.
//  A result waiting under out_stall blocks the next input beat, and holds
//  back the wrap cycle of a running divide, until it is taken.
//
// ----------------------------------------------------------------------------
`default_nettype none

module edge_phase_meter (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel: one sample pair per beat.
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [epm_pkg::SAMPLE_BITS-1:0] in_x_sample,
  input  wire logic signed [epm_pkg::SAMPLE_BITS-1:0] in_ref_sample,
  // Result channel: zero or one phase beat per input beat.
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [epm_pkg::PHASE_BITS-1:0]       out_phase,
  // Configuration write port: index 0 is edge_mode, index 1 is sync_mode.
  input  wire logic                                   cfg_wr_en,
  input  wire logic [epm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [epm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import epm_pkg::*;

  // Commands flow from the controller into the datapath, status flows back.
  epm_cmd_t cmd;
  epm_sts_t sts;

  // The controller decides when beats are taken and when results appear.
  epm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the measurement state, the divider and the result.
  epm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_x_sample   (in_x_sample),
    .in_ref_sample (in_ref_sample),
    .out_phase     (out_phase),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/core/epm_ctrl.sv =====
// ----------------------------------------------------------------------------
// epm_ctrl: controller of the edge phase meter
// Sequences the accept, multiply, divide and finish steps and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire epm_pkg::epm_sts_t sts,
  output epm_pkg::epm_cmd_t     cmd
);
  import epm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // The result register is free in the next cycle if it is empty or taken now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.load       = accept;
    cmd.emit_sync  = accept && !sts.x_edge && sts.sync_mode;
    case (state_r)
      S_IDLE: begin
        if (accept && sts.x_edge) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.emit_sync || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is only written into a register that is free.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free)
    else $error("result written while the previous one is still pending");

  // A pending result is never overwritten or dropped.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("pending result lost");

  // A signal edge always launches the division sequence.
  a_edge_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.x_edge) |=> (state_r == S_MUL))
    else $error("signal edge did not start the phase division");

  // The division runs until its final step before the phase is finished.
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_last) |=> (state_r == S_DIV))
    else $error("division left early");

endmodule

`default_nettype wire

// ===== rtl/core/epm_dp.sv =====
// ----------------------------------------------------------------------------
// epm_dp: datapath of the edge phase meter
// Edge detection, sample counters, period latch, the numerator multiply,
// a restoring divider that folds the quotient modulo a full turn, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic signed [epm_pkg::SAMPLE_BITS-1:0] in_x_sample,
  input  wire logic signed [epm_pkg::SAMPLE_BITS-1:0] in_ref_sample,
  output logic signed [epm_pkg::PHASE_BITS-1:0]       out_phase,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [epm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [epm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire epm_pkg::epm_cmd_t                      cmd,
  output epm_pkg::epm_sts_t                           sts
);
  import epm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                    edge_mode_r, edge_mode_nxt;
  logic                    sync_mode_r, sync_mode_nxt;
  logic                    prev_x_r, prev_x_nxt;
  logic                    prev_ref_r, prev_ref_nxt;
  logic [COUNT_BITS-1:0]   ref_cnt_r, ref_cnt_nxt;
  logic [COUNT_BITS-1:0]   x_cnt_r, x_cnt_nxt;
  logic [PERIOD_BITS-1:0]  period_r, period_nxt;
  logic                    cnt_on_r, cnt_on_nxt;
  logic [PHASE_BITS-1:0]   last_phase_r, last_phase_nxt;
  logic [DIV_CNT_BITS-1:0] div_cnt_r, div_cnt_nxt;
  logic [NUM_BITS-1:0]     num_r, num_nxt;
  logic [PERIOD_BITS-1:0]  rem_r, rem_nxt;
  logic [PHASE_BITS-1:0]   rmod_r, rmod_nxt;
  logic [PHASE_BITS-1:0]   out_phase_r, out_phase_nxt;

  logic                    x_high, ref_high, x_edge, ref_edge;
  logic                    cnt_on_tmp;
  logic [COUNT_BITS-1:0]   x_cnt_tmp;
  logic [PERIOD_BITS:0]    trial;
  logic                    q_bit;
  logic [TURN_BITS-1:0]    rmod_dbl;
  logic [PHASE_BITS-1:0]   phase_val;

  assign x_high   = in_x_sample > HIGH_THRESHOLD;
  assign ref_high = in_ref_sample > HIGH_THRESHOLD;
  assign x_edge   = edge_mode_r ? (x_high && !prev_x_r) : (!x_high && prev_x_r);
  assign ref_edge = edge_mode_r ? (ref_high && !prev_ref_r) : (!ref_high && prev_ref_r);

  assign sts.x_edge    = x_edge;
  assign sts.sync_mode = sync_mode_r;
  assign sts.div_last  = (div_cnt_r == DIV_CNT_BITS'(NUM_BITS - 1));

  // One restoring step: the quotient bit also feeds a running residue
  // modulo a full turn, so the wrap needs no wide remainder at the end.
  assign trial    = {rem_r, num_r[NUM_BITS-1]};
  assign q_bit    = trial >= {1'b0, period_r};
  assign rmod_dbl = {rmod_r, q_bit};

  always_comb begin
    if (period_r == '0) begin
      phase_val = '0;
    end else if (rmod_r > HALF_TURN) begin
      phase_val = PHASE_BITS'({1'b0, rmod_r} - FULL_TURN);
    end else begin
      phase_val = rmod_r;
    end
  end

  always_comb begin
    edge_mode_nxt  = edge_mode_r;
    sync_mode_nxt  = sync_mode_r;
    prev_x_nxt     = prev_x_r;
    prev_ref_nxt   = prev_ref_r;
    ref_cnt_nxt    = ref_cnt_r;
    x_cnt_nxt      = x_cnt_r;
    period_nxt     = period_r;
    cnt_on_nxt     = cnt_on_r;
    last_phase_nxt = last_phase_r;
    div_cnt_nxt    = div_cnt_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    rmod_nxt       = rmod_r;
    out_phase_nxt  = out_phase_r;
    cnt_on_tmp     = cnt_on_r;
    x_cnt_tmp      = x_cnt_r;

    if (cfg_wr_en) begin
      if (cfg_index == REG_EDGE_MODE) begin
        edge_mode_nxt = cfg_data[0];
      end
      if (cfg_index == REG_SYNC_MODE) begin
        sync_mode_nxt = cfg_data[0];
      end
    end

    if (cmd.load) begin
      prev_x_nxt   = x_high;
      prev_ref_nxt = ref_high;
      if (ref_edge) begin
        cnt_on_tmp  = 1'b1;
        period_nxt  = {1'b0, ref_cnt_r} + PERIOD_BITS'(1);
        ref_cnt_nxt = '0;
        x_cnt_tmp   = '0;
      end else if (ref_cnt_r != COUNT_MAX) begin
        ref_cnt_nxt = ref_cnt_r + COUNT_BITS'(1);
      end
      cnt_on_nxt = cnt_on_tmp;
      x_cnt_nxt  = x_cnt_tmp;
      if (x_edge) begin
        cnt_on_nxt = 1'b0;
      end else if (cnt_on_tmp && x_cnt_tmp != COUNT_MAX) begin
        x_cnt_nxt = x_cnt_tmp + COUNT_BITS'(1);
      end
    end

    if (cmd.emit_sync) begin
      out_phase_nxt = last_phase_r;
    end

    if (cmd.mul) begin
      num_nxt     = NUM_BITS'(x_cnt_r) * NUM_BITS'(FULL_TURN);
      rem_nxt     = '0;
      rmod_nxt    = '0;
      div_cnt_nxt = '0;
    end

    if (cmd.step) begin
      num_nxt     = {num_r[NUM_BITS-2:0], 1'b0};
      rem_nxt     = q_bit ? PERIOD_BITS'(trial - {1'b0, period_r})
                          : PERIOD_BITS'(trial);
      rmod_nxt    = (rmod_dbl >= FULL_TURN) ? PHASE_BITS'(rmod_dbl - FULL_TURN)
                                            : rmod_dbl[PHASE_BITS-1:0];
      div_cnt_nxt = div_cnt_r + DIV_CNT_BITS'(1);
    end

    if (cmd.finish) begin
      last_phase_nxt = phase_val;
      out_phase_nxt  = phase_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mode_r  <= 1'b1;
      sync_mode_r  <= 1'b1;
      prev_x_r     <= 1'b0;
      prev_ref_r   <= 1'b0;
      ref_cnt_r    <= '0;
      x_cnt_r      <= '0;
      period_r     <= '0;
      cnt_on_r     <= 1'b0;
      last_phase_r <= '0;
      div_cnt_r    <= '0;
    end else begin
      edge_mode_r  <= edge_mode_nxt;
      sync_mode_r  <= sync_mode_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_ref_r   <= prev_ref_nxt;
      ref_cnt_r    <= ref_cnt_nxt;
      x_cnt_r      <= x_cnt_nxt;
      period_r     <= period_nxt;
      cnt_on_r     <= cnt_on_nxt;
      last_phase_r <= last_phase_nxt;
      div_cnt_r    <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    rmod_r      <= rmod_nxt;
    out_phase_r <= out_phase_nxt;
  end

  assign out_phase = $signed(out_phase_r);

endmodule

`default_nettype wire

// ===== dv/edge_phase_meter_checker.sv =====
// ----------------------------------------------------------------------------
// edge_phase_meter_checker: phase prediction and result comparison
// Watches the sample, result and register ports of the edge phase meter. It
// keeps its own copy of the edge, counter and period state, works out the
// phase beats that every accepted sample pair should cause, and compares
// them in order with the beats that leave the block.
// ----------------------------------------------------------------------------

module edge_phase_meter_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic signed [epm_pkg::SAMPLE_BITS-1:0] in_x_sample,
  input  logic signed [epm_pkg::SAMPLE_BITS-1:0] in_ref_sample,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [epm_pkg::PHASE_BITS-1:0]  out_phase,
  input  logic                                   cfg_wr_en,
  input  logic [epm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [epm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output int                                     fail_cnt,
  output int                                     phase_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import epm_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] HIGH_LEVEL      = 16'sd2048;
  localparam longint unsigned               TURN_UNITS      = 46080;
  localparam int                            HALF_TURN_UNITS = 23040;

  logic                          edge_rising;
  logic                          sync_repeat;
  logic                          prev_x_hi;
  logic                          prev_ref_hi;
  logic [COUNT_BITS-1:0]         ref_cnt;
  logic [COUNT_BITS-1:0]         x_cnt;
  logic [COUNT_BITS:0]           period;
  logic                          counting;
  logic signed [PHASE_BITS-1:0]  last_phase;
  logic signed [PHASE_BITS-1:0]  phase_q[$];
  logic signed [PHASE_BITS-1:0]  expected;
  int                            fails;

  // Advances the meter by one sample pair and queues the phase it reports.
  task automatic step_meter(input logic signed [SAMPLE_BITS-1:0] xs,
                            input logic signed [SAMPLE_BITS-1:0] rs);
    logic            x_hi;
    logic            r_hi;
    logic            x_edge;
    logic            r_edge;
    longint unsigned turns;
    int              ph;
    x_hi   = xs > HIGH_LEVEL;
    r_hi   = rs > HIGH_LEVEL;
    x_edge = edge_rising ? (x_hi && !prev_x_hi) : (prev_x_hi && !x_hi);
    r_edge = edge_rising ? (r_hi && !prev_ref_hi) : (prev_ref_hi && !r_hi);
    prev_x_hi   = x_hi;
    prev_ref_hi = r_hi;

    if (r_edge) begin
      counting = 1'b1;
      period   = ref_cnt + 1'b1;
      ref_cnt  = '0;
      x_cnt    = '0;
    end else if (ref_cnt != '1) begin
      ref_cnt++;
    end

    if (x_edge) begin
      counting = 1'b0;
      ph = 0;
      if (period != '0) begin
        // Truncate first, then fold into the half-open range around zero.
        turns = x_cnt;
        turns = (turns * TURN_UNITS) / period;
        ph    = int'(turns % TURN_UNITS);
        if (ph > HALF_TURN_UNITS) ph -= int'(TURN_UNITS);
      end
      last_phase = ph[PHASE_BITS-1:0];
      phase_q.push_back(last_phase);
    end else begin
      if (sync_repeat) phase_q.push_back(last_phase);
      if (counting && x_cnt != '1) x_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_rising = 1'b1;
      sync_repeat = 1'b1;
      prev_x_hi   = 1'b0;
      prev_ref_hi = 1'b0;
      ref_cnt     = '0;
      x_cnt       = '0;
      period      = '0;
      counting    = 1'b0;
      last_phase  = '0;
      phase_q.delete();
    end else begin
      // A result leaves before the beat taken at the same edge can add one.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (phase_q.size() == 0) begin
          $error("phase: expected none, actual %0d", out_phase);
          fails++;
        end else begin
          expected = phase_q.pop_front();
          if (out_phase !== expected) begin
            $error("phase: expected %0d, actual %0d", expected, out_phase);
            fails++;
          end
        end
      end
      if (cfg_wr_en === 1'b1) begin
        case (cfg_index)
          REG_EDGE_MODE: edge_rising = cfg_data[0];
          REG_SYNC_MODE: sync_repeat = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) step_meter(in_x_sample, in_ref_sample);
    end
    fail_cnt      <= fails;
    phase_pending <= phase_q.size();
  end

endmodule

// ===== dv/edge_phase_meter_tb.sv =====
// ----------------------------------------------------------------------------
// edge_phase_meter_tb: top level of the edge phase meter testbench
// Drives sample pairs and register writes into the meter, stalls the result
// channel at random, and leaves prediction and comparison to the checker
// that sits beside the block. A short directed run comes first, then square
// waves of random period, duty and lag under every register setting.
// ----------------------------------------------------------------------------

module edge_phase_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epm_pkg::*;

  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 160;
  localparam int DRAIN_LIMIT   = 5000;

  logic                          clk;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_x_sample   = '0;
  logic signed [SAMPLE_BITS-1:0] in_ref_sample = '0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic signed [PHASE_BITS-1:0]  out_phase;
  logic                          cfg_wr_en     = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index     = REG_EDGE_MODE;
  logic [CFG_DATA_BITS-1:0]      cfg_data      = '0;
  int                            fail_cnt;
  int                            phase_pending;

  // Each side toggles now and then into a stretch where it never idles.
  bit in_rush;
  bit out_rush;

  edge_phase_meter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_sample  (in_x_sample),
    .in_ref_sample(in_ref_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_phase    (out_phase),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  edge_phase_meter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_sample  (in_x_sample),
    .in_ref_sample(in_ref_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_phase    (out_phase),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_cnt     (fail_cnt),
    .phase_pending(phase_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the meter hangs; the slowest correct run is far shorter.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // Picks a sample on the chosen side of the threshold. The threshold itself
  // and the full-scale values turn up often, since they decide the edges.
  function automatic logic signed [SAMPLE_BITS-1:0] level_sample(input bit hi);
    int v;
    case ($urandom_range(0, 3))
      0: v = hi ? 32767 : -32768;
      1: v = hi ? 2049 : 2048;
      default: begin
        if (hi) v = int'($urandom_range(2049, 32767));
        else v = int'($urandom_range(0, 34816)) - 32768;
      end
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Offers one sample pair after a random gap and returns at the edge where
  // the beat is taken. Valid stays high across back-to-back beats.
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] xs,
                           input logic signed [SAMPLE_BITS-1:0] rs);
    int gap;
    if ($urandom_range(0, 39) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_x_sample   <= xs;
    in_ref_sample <= rs;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Lets every expected phase beat out, then waits out a full divide in case
  // the last beat was one that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (phase_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both mode registers, then one index that the block must ignore.
  task automatic program_meter(input logic rising, input logic sync_rep);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_EDGE_MODE;
    cfg_data  <= rising;
    @(posedge clk);
    cfg_index <= REG_SYNC_MODE;
    cfg_data  <= sync_rep;
    @(posedge clk);
    cfg_index <= CFG_INDEX_BITS'($urandom_range(REG_SYNC_MODE + 1, 2**CFG_INDEX_BITS - 1));
    cfg_data  <= CFG_DATA_BITS'($urandom_range(0, 1));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends bursts of square waves: a reference of random period and duty, and
  // a measured signal at a random lag, sometimes drifting by one sample per
  // period so that the phase walks through both halves of the turn. Most
  // periods are short to keep the run quick; a few are long. Some bursts are
  // pure noise, and single glitches break up the clean waves now and then.
  task automatic send_waves(input int count);
    int  per;
    int  x_per;
    int  ref_hi_len;
    int  x_hi_len;
    int  lag;
    int  len;
    bit  noisy;
    logic signed [SAMPLE_BITS-1:0] xs;
    logic signed [SAMPLE_BITS-1:0] rs;
    while (count > 0) begin
      per   = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 150) : $urandom_range(2, 24);
      x_per = per;
      if ($urandom_range(0, 3) == 0) x_per = per + $urandom_range(0, 2) - 1;
      if (x_per < 2) x_per = 2;
      ref_hi_len = $urandom_range(1, per - 1);
      x_hi_len   = $urandom_range(1, x_per - 1);
      lag        = $urandom_range(0, 2 * per);
      len        = $urandom_range(per, 3 * per);
      noisy      = ($urandom_range(0, 7) == 0);
      if (len > count) len = count;
      for (int k = 0; k < len; k++) begin
        if (noisy || $urandom_range(0, 29) == 0) begin
          xs = SAMPLE_BITS'($urandom);
          rs = SAMPLE_BITS'($urandom);
        end else begin
          xs = level_sample(((k + lag) % x_per) < x_hi_len);
          rs = level_sample((k % per) < ref_hi_len);
        end
        send_pair(xs, rs);
      end
      count -= len;
    end
  endtask

  // Result side: stalls for a random number of cycles before each beat.
  initial begin : result_sink
    int n;
    forever begin
      if ($urandom_range(0, 39) == 0) out_rush = !out_rush;
      n = out_rush ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed run in the reset setting: rising edges, last phase repeated.
    // Both inputs low at full negative scale, then a signal edge with no
    // reference edge yet, which must report zero for the empty period.
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, 16'sd2048);
    // Reference edge just above the threshold, period of three samples.
    send_pair(16'sd2048, 16'sd2049);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0);
    // Signal edge after exactly one period: a whole turn folds to zero.
    send_pair(16'sd2049, 16'sd0);
    // Four-sample period with the signal edge half way: the top of the range.
    send_pair(-16'sd1, 16'sd32767);
    send_pair(-16'sd1, 16'sd2048);
    send_pair(16'sd16384, -16'sd2);
    send_pair(16'sd0, 16'sd0);
    // Three quarters of a turn must come out on the negative side.
    send_pair(16'sd0, 16'sd30000);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd2049);
    send_pair(16'sd0, 16'sd0);
    // Both edges in one beat: the counters clear first, so the phase is zero.
    send_pair(16'sd32767, 16'sd32767);
    settle();

    // Falling edges without repeats: only beats with a signal edge report.
    program_meter(1'b0, 1'b0);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(16'sd32767, 16'sd2048);
    send_pair(16'sd2048, 16'sd2048);
    settle();

    // Random waves under each corner of the two modes, then a random setting.
    program_meter(1'b1, 1'b1);
    send_waves(PHASE_ITEMS);
    settle();
    program_meter(1'b0, 1'b0);
    send_waves(PHASE_ITEMS);
    settle();
    program_meter(1'b1, 1'b0);
    send_waves(PHASE_ITEMS);
    settle();
    program_meter(1'b0, 1'b1);
    send_waves(PHASE_ITEMS);
    settle();
    program_meter(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_waves(PHASE_ITEMS);

    in_valid <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && phase_pending != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && phase_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== edge_phase_meter.f =====
rtl/core/epm_pkg.sv
rtl/core/epm_ctrl.sv
rtl/core/epm_dp.sv
rtl/core/edge_phase_meter.sv
dv/edge_phase_meter_checker.sv
dv/edge_phase_meter_tb.sv
